>>> src/lhob_pkg.sv
// ----------------------------------------------------------------------------
// lhob_pkg
// shared types, constants and command codes for the lzma header obfuscator
// ----------------------------------------------------------------------------
`default_nettype none

package lhob_pkg;

  localparam int BLOCK_BYTES = 16384;
  localparam int XOR_SPAN    = 8;
  localparam int OFS_W       = $clog2(BLOCK_BYTES);

  localparam int HDR_IN_LEN  = 13;
  localparam int HDR_KEEP    = 9;
  localparam int HDR_OUT_LEN = 16;
  localparam int CNT_W       = $clog2(HDR_OUT_LEN);
  localparam int STORE_W     = $clog2(HDR_KEEP);

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [15:0] MAGIC   = 16'h5E71;
  localparam logic [15:0] SPECIAL = 16'h0101;
  localparam logic [7:0]  PB_KEY  = 8'h37;
  localparam logic [7:0]  LP_KEY  = 8'h5E;
  localparam logic [7:0]  LC_KEY  = 8'hB9;

  localparam logic [1:0] KIND_PASS  = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_HDR   = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       short_error;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [7:0]                data;
    logic                      last;
    logic [HDR_KEEP-1:0][7:0]  hdr;
  } cmd_t;

endpackage

`default_nettype wire

>>> src/lhob_front.sv
// ----------------------------------------------------------------------------
// lhob_front
// collects the classic header, tracks payload offset and issues commands
// ----------------------------------------------------------------------------
`default_nettype none

module lhob_front import lhob_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire in_beat_t din,
  output logic          cmd_push,
  output cmd_t          cmd
);

  logic [HDR_KEEP-1:0][7:0] store;
  logic [CNT_W-1:0]         header_count;
  logic                     in_payload;
  logic [OFS_W-1:0]         block_offset;

  logic [CNT_W-1:0]         count_inc;
  logic [7:0]               key;
  logic                     hdr_done;

  assign count_inc = header_count + CNT_W'(1);
  assign hdr_done  = (count_inc == CNT_W'(HDR_IN_LEN));
  assign key       = (32'(block_offset) < 32'(XOR_SPAN)) ? 8'(block_offset) : 8'h00;

  always_comb begin
    cmd_push = 1'b0;
    cmd.kind = KIND_PASS;
    cmd.data = din.in_byte ^ key;
    cmd.last = din.in_last;
    cmd.hdr  = store;
    if (accept) begin
      if (in_payload) begin
        cmd_push = 1'b1;
      end else if (hdr_done) begin
        cmd_push = 1'b1;
        cmd.kind = KIND_HDR;
      end else if (din.in_last) begin
        cmd_push = 1'b1;
        cmd.kind = KIND_SHORT;
        cmd.data = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_payload && (32'(header_count) < HDR_KEEP)) begin
      store[STORE_W'(header_count)] <= din.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      in_payload   <= 1'b0;
      block_offset <= '0;
    end else if (accept) begin
      if (in_payload) begin
        if (block_offset == OFS_W'(BLOCK_BYTES - 1)) begin
          block_offset <= '0;
        end else begin
          block_offset <= block_offset + OFS_W'(1);
        end
        if (din.in_last) begin
          header_count <= '0;
          in_payload   <= 1'b0;
          block_offset <= '0;
        end
      end else if (din.in_last) begin
        header_count <= '0;
        block_offset <= '0;
      end else begin
        header_count <= count_inc;
        if (hdr_done) begin
          in_payload   <= 1'b1;
          block_offset <= '0;
        end
      end
    end
  end

  // payload mode only follows a complete header
  assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (header_count == CNT_W'(HDR_IN_LEN)))
    else $error("payload mode without a complete header");

  assert property (@(posedge clk) disable iff (rst)
    !in_payload |-> (32'(header_count) < HDR_IN_LEN))
    else $error("header count past header length");

endmodule

`default_nettype wire

>>> src/lhob_queue.sv
// ----------------------------------------------------------------------------
// lhob_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module lhob_queue import lhob_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd,
  output logic      valid,
  output cmd_t      head
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + QCNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(wr && full && !rd))
    else $error("queue overflow");

  assert property (@(posedge clk) disable iff (rst) !(rd && !valid))
    else $error("queue underflow");

endmodule

`default_nettype wire

>>> src/lhob_back.sv
// ----------------------------------------------------------------------------
// lhob_back
// expands commands into result beats and holds the output register
// ----------------------------------------------------------------------------
`default_nettype none

module lhob_back import lhob_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      empty,
  input  wire logic pop,
  output out_beat_t dout
);

  logic [CNT_W-1:0] idx;
  logic             out_valid;
  logic             load;
  logic             idx_end;
  out_beat_t        res;

  logic [13:0]      prod9;
  logic [4:0]       q9;
  logic [8:0]       prod45;
  logic [2:0]       q45;
  logic [7:0]       lc;
  logic [7:0]       lp;
  logic [7:0]       pb;
  logic [7:0]       hbyte;

  // props split by reciprocal multiply, exact over 0..255
  assign prod9  = 14'(cmd.hdr[0]) * 14'd57;
  assign q9     = prod9[13:9];
  assign prod45 = 9'(q9) * 9'd13;
  assign q45    = prod45[8:6];
  assign lc     = cmd.hdr[0] - 8'(q9) * 8'd9;
  assign lp     = 8'(q9) - 8'(q45) * 8'd5;
  assign pb     = 8'(q45);

  always_comb begin
    unique case (idx)
      4'd0:    hbyte = MAGIC[15:8];
      4'd1:    hbyte = MAGIC[7:0];
      4'd2:    hbyte = SPECIAL[15:8];
      4'd3:    hbyte = SPECIAL[7:0];
      4'd4:    hbyte = pb ^ PB_KEY;
      4'd5:    hbyte = lp ^ LP_KEY;
      4'd6:    hbyte = lc ^ LC_KEY;
      4'd7:    hbyte = 8'h00;
      4'd8:    hbyte = cmd.hdr[3];
      4'd9:    hbyte = cmd.hdr[2];
      4'd10:   hbyte = cmd.hdr[1];
      4'd11:   hbyte = cmd.hdr[4];
      4'd12:   hbyte = cmd.hdr[8];
      4'd13:   hbyte = cmd.hdr[7];
      4'd14:   hbyte = cmd.hdr[6];
      4'd15:   hbyte = cmd.hdr[5];
      default: hbyte = 8'h00;
    endcase
  end

  assign idx_end = (idx == CNT_W'(HDR_OUT_LEN - 1));
  assign load    = cmd_valid && (!out_valid || pop);
  assign cmd_pop = load && ((cmd.kind != KIND_HDR) || idx_end);
  assign empty   = !out_valid;

  always_comb begin
    res.out_byte    = cmd.data;
    res.out_last    = cmd.last;
    res.short_error = 1'b0;
    unique case (cmd.kind)
      KIND_SHORT: begin
        res.out_byte    = 8'h00;
        res.out_last    = 1'b1;
        res.short_error = 1'b1;
      end
      KIND_HDR: begin
        res.out_byte = hbyte;
        res.out_last = cmd.last && idx_end;
      end
      default: begin
        res.out_byte = cmd.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load && (cmd.kind == KIND_HDR)) begin
        idx <= idx_end ? '0 : idx + CNT_W'(1);
      end
    end
  end

  // a header burst in progress keeps its command at the queue head
  assert property (@(posedge clk) disable iff (rst)
    (idx != '0) |-> (cmd_valid && (cmd.kind == KIND_HDR)))
    else $error("header burst lost its command");

endmodule

`default_nettype wire

>>> src/lzma_header_obfuscator_top.sv
// ----------------------------------------------------------------------------
// lzma_header_obfuscator_top
// rewrites a raw lzma stream header into the obfuscated form and masks payload
// ----------------------------------------------------------------------------
//  channel   signals              beat
//  input     push, full, din      one raw stream byte with last flag
//  output    pop, empty, dout     one output byte, last flag, short error
//
//  payload bytes pass the command queue and the output register, one beat
//  per cycle while pop is held; the thirteenth header byte expands to sixteen
//  beats, one per cycle while pop is held, from the back part; the two-entry
//  command queue absorbs input meanwhile, and full rises only when it holds two commands
//  rst is synchronous and clears all stream state and the queue
// ----------------------------------------------------------------------------
`default_nettype none

module lzma_header_obfuscator_top import lhob_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_beat_t din,
  output logic          empty,
  input  wire logic     pop,
  output out_beat_t     dout
);

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_pop;
  logic cmd_valid;
  cmd_t cmd_head;

  assign accept = push && !full;

  lhob_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .din      (din),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  lhob_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd_in),
    .full    (full),
    .rd      (cmd_pop),
    .valid   (cmd_valid),
    .head    (cmd_head)
  );

  lhob_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .dout      (dout)
  );

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lzma header obfuscator
//
// Starts with a short table of streams: an early end, a full header and
// payload bytes at the edges of the xor window. Then it sends random streams,
// mostly well formed with random content, plus short and ragged ones.
// The streams run under four idle patterns on the input and output sides.
// Every output beat is compared with a local model of the header rewrite
// and the payload mask, or with the expected beat of its table row.
// ----------------------------------------------------------------------------
module tb_top;
  import lhob_pkg::*;

  localparam int DIR_ROWS     = 23;
  localparam int PHASE_BEATS  = 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_beat_t  din = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_beat_t dout;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned beats_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  out_beat_t   expected_bytes [$];
  stim_row_t   dir_tab [DIR_ROWS];

  // model state
  logic [7:0]       hdr_keep [HDR_KEEP];
  logic [CNT_W-1:0] hdr_seen = '0;
  logic             payload_on = 1'b0;
  logic [OFS_W-1:0] blk_ofs = '0;

  lzma_header_obfuscator_top dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .din(din),
    .empty(empty),
    .pop(pop),
    .dout(dout)
  );

  always #6 clk = ~clk;

  function automatic out_beat_t beat_of(logic [7:0] v, logic l, logic e);
    out_beat_t r;
    r.out_byte = v;
    r.out_last = l;
    r.short_error = e;
    return r;
  endfunction

  function automatic stim_row_t plain(logic [7:0] v, logic l);
    stim_row_t r;
    r.beat.in_byte = v;
    r.beat.in_last = l;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [7:0] v, logic l, logic [7:0] w, logic wl,
                                          logic we);
    stim_row_t r;
    r = plain(v, l);
    r.typed = 1'b1;
    r.want = beat_of(w, wl, we);
    return r;
  endfunction

  task automatic end_stream();
    hdr_seen = '0;
    payload_on = 1'b0;
    blk_ofs = '0;
  endtask

  // updates the stream state; queues the beats it produces when emit is set
  task automatic obfuscate(input in_beat_t b, input logic emit);
    logic [7:0] props;
    logic [7:0] hdr [HDR_OUT_LEN];
    if (payload_on) begin
      if (emit) begin
        expected_bytes.push_back(beat_of(b.in_byte ^ ((blk_ofs < XOR_SPAN) ? 8'(blk_ofs) : 8'h00),
                                         b.in_last, 1'b0));
      end
      blk_ofs = blk_ofs + 1'b1;
      if (b.in_last) end_stream();
    end else begin
      if (hdr_seen < HDR_KEEP) hdr_keep[hdr_seen] = b.in_byte;
      hdr_seen = hdr_seen + 1'b1;
      if (hdr_seen < HDR_IN_LEN) begin
        if (b.in_last) begin
          if (emit) expected_bytes.push_back(beat_of(8'h00, 1'b1, 1'b1));
          end_stream();
        end
      end else begin
        props = hdr_keep[0];
        hdr = '{MAGIC[15:8], MAGIC[7:0], SPECIAL[15:8], SPECIAL[7:0],
                PB_KEY ^ (props / 8'd45), LP_KEY ^ ((props / 8'd9) % 8'd5),
                LC_KEY ^ (props % 8'd9), 8'h00,
                hdr_keep[3], hdr_keep[2], hdr_keep[1], hdr_keep[4],
                hdr_keep[8], hdr_keep[7], hdr_keep[6], hdr_keep[5]};
        if (emit) begin
          for (int i = 0; i < HDR_OUT_LEN; i++) begin
            expected_bytes.push_back(beat_of(hdr[i], (i == HDR_OUT_LEN - 1) ? b.in_last : 1'b0,
                                             1'b0));
          end
        end
        if (b.in_last) begin
          end_stream();
        end else begin
          payload_on = 1'b1;
          blk_ofs = '0;
        end
      end
    end
  endtask

  task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    din  <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    obfuscate(b, !typed);
    if (typed) expected_bytes.push_back(want);
    beats_sent++;
  endtask

  task automatic send_stream(input int len);
    in_beat_t b;
    for (int i = 0; i < len; i++) begin
      b.in_byte = 8'($urandom);
      if (i == 0 && $urandom_range(2) == 0) b.in_byte = $urandom_range(1) ? 8'hFF : 8'h00;
      b.in_last = (i == len - 1);
      send_beat(b, 1'b0, '0);
    end
  endtask

  task automatic random_stream();
    int       pick;
    int       n;
    in_beat_t b;
    pick = $urandom_range(99);
    if (pick < 72) begin
      n = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(1, 24));
      send_stream(HDR_IN_LEN + n);
    end else if (pick < 90) begin
      send_stream(int'($urandom_range(1, HDR_IN_LEN - 1)));
    end else begin
      // ragged stream, ends scattered at random
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
        b.in_byte = 8'($urandom);
        b.in_last = (i == n - 1) || ($urandom_range(7) == 0);
        send_beat(b, 1'b0, '0);
      end
    end
  endtask

  task automatic check_beat(input out_beat_t got);
    out_beat_t want;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) begin
        $display("unexpected beat: byte %02h last %0b err %0b",
                 got.out_byte, got.out_last, got.short_error);
      end
    end else begin
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
          got.short_error !== want.short_error) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
          $display("mismatch: expected byte %02h last %0b err %0b, got byte %02h last %0b err %0b",
                   want.out_byte, want.out_last, want.short_error,
                   got.out_byte, got.out_last, got.short_error);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_beat(dout);
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned phase_start;
    dir_tab = '{
      // stream ends on its first byte
      typed_row(8'hFF, 1'b1, 8'h00, 1'b1, 1'b1),
      // props, dictionary, size with high bytes dropped
      plain(8'hFF, 1'b0),
      plain(8'h00, 1'b0), plain(8'hFF, 1'b0), plain(8'h12, 1'b0), plain(8'h80, 1'b0),
      plain(8'h01, 1'b0), plain(8'h02, 1'b0), plain(8'h03, 1'b0), plain(8'h04, 1'b0),
      plain(8'hFF, 1'b0), plain(8'hFF, 1'b0), plain(8'hFF, 1'b0), plain(8'hFF, 1'b0),
      // payload across the xor window
      typed_row(8'hFF, 1'b0, 8'hFF, 1'b0, 1'b0),
      typed_row(8'h00, 1'b0, 8'h01, 1'b0, 1'b0),
      typed_row(8'hFF, 1'b0, 8'hFD, 1'b0, 1'b0),
      typed_row(8'h00, 1'b0, 8'h03, 1'b0, 1'b0),
      typed_row(8'hFF, 1'b0, 8'hFB, 1'b0, 1'b0),
      typed_row(8'h00, 1'b0, 8'h05, 1'b0, 1'b0),
      typed_row(8'hFF, 1'b0, 8'hF9, 1'b0, 1'b0),
      typed_row(8'h00, 1'b0, 8'h07, 1'b0, 1'b0),
      typed_row(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 52;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 52;
        end
        default: begin
          tx_idle_pct = 17;
          rx_stall_pct = 17;
        end
      endcase
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) random_stream();
    end
    push <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lhob_pkg.sv
src/lhob_front.sv
src/lhob_queue.sv
src/lhob_back.sv
src/lzma_header_obfuscator_top.sv
test/tb_top.sv
